### sv/ldl_pkg.sv
package ldl_pkg;

   localparam int DVD_W      = 68;
   localparam int CNT_W      = 7;
   localparam int IDX_W      = 5;
   localparam int S_W        = 40;
   localparam int Q_SHIFT    = 30;
   localparam int FRAC_SHIFT = 28;
   localparam int X_BITS     = 60;
   localparam int T_BITS     = 40;
   localparam int F_BITS     = 68;
   localparam int ANGLE_MUL  = 205;
   localparam int ANGLE_SHR  = 11;
   localparam int FIU_RESET  = 32;

   typedef enum logic [1:0] {
      FUNC_FIELD = 2'd0,
      FUNC_SPEED = 2'd1,
      FUNC_COEF  = 2'd2,
      FUNC_QUERY = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_FIELD  = 3'd1,
      ST_BAD_ANGLE = 3'd2,
      ST_LOAD_DONE = 3'd3,
      ST_SATURATED = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_SRCH, S_SCMP, S_CHK, S_BCAP, S_RANGE, S_XDIV, S_C0,
      S_MUL, S_XP, S_T, S_TSTART, S_TDIV, S_CRD, S_CMUL, S_CACC, S_NEXT,
      S_FSTART, S_FDIV, S_FIN
   } state_type;

   typedef struct packed {
      logic capture;
      logic load_wr;
      logic set_load;
      logic set_nf;
      logic set_ang;
      logic srch_rd;
      logic srch_step;
      logic chk_rd;
      logic b_rd;
      logic b_cap;
      logic x_start;
      logic x_done;
      logic c0_cap;
      logic mul_x;
      logic xp_cap;
      logic t_cap;
      logic t_start;
      logic p_upd;
      logic c_rd;
      logic c_mul;
      logic c_acc;
      logic i_inc;
      logic f_start;
      logic f_done;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic first_ok;
      logic less;
      logic hit;
      logic angle_ok;
      logic out_range;
      logic div_done;
      logic even_next;
      logic last_i;
      logic no_loop;
   } flag_type;

endpackage

### sv/ldl_ram.sv
module ldl_ram import ldl_pkg::*; #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ldl_div.sv
module ldl_div import ldl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [31:0]      divisor,
   input  logic [CNT_W-1:0] nbits,
   output logic             run,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   logic [DVD_W-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [31:0]      rem_ff, rem_in, den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in, done_ff, done_in;
   logic [32:0]      trial, diff;
   logic             ge;

   assign trial = {rem_ff, num_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = dividend << (CNT_W'(DVD_W) - nbits);
         quo_in = '0;
         rem_in = '0;
         den_in = divisor;
         cnt_in = nbits;
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in  = num_ff << 1;
         quo_in  = {quo_ff[DVD_W-2:0], ge};
         rem_in  = ge ? diff[31:0] : trial[31:0];
         cnt_in  = cnt_ff - 1'b1;
         run_in  = cnt_ff != CNT_W'(1);
         done_in = cnt_ff == CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign run      = run_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### sv/ldl_ctrl.sv
module ldl_ctrl import ldl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic [1:0] func,
   input  flag_type flags,
   output cmd_type  cmd,
   output logic     busy
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = (func_type'(func) == FUNC_QUERY) ? S_SRCH : S_LOAD;
            end
         end
         S_LOAD: state_in = S_FIN;
         S_SRCH: begin
            if (!flags.cnt_zero) begin
               state_in = S_SCMP;
            end else if (flags.first_ok) begin
               state_in = S_CHK;
            end else begin
               state_in = S_FIN;
            end
         end
         S_SCMP: state_in = S_SRCH;
         S_CHK: begin
            state_in = (flags.hit && flags.angle_ok) ? S_BCAP : S_FIN;
         end
         S_BCAP: state_in = S_RANGE;
         S_RANGE: state_in = flags.out_range ? S_FIN : S_XDIV;
         S_XDIV: begin
            if (flags.div_done) begin
               state_in = S_C0;
            end
         end
         S_C0: state_in = flags.no_loop ? S_FSTART : S_MUL;
         S_MUL: state_in = S_XP;
         S_XP: state_in = S_T;
         S_T: state_in = S_TSTART;
         S_TSTART: state_in = S_TDIV;
         S_TDIV: begin
            if (flags.div_done) begin
               state_in = flags.even_next ? S_CRD : S_NEXT;
            end
         end
         S_CRD: state_in = S_CMUL;
         S_CMUL: state_in = S_CACC;
         S_CACC: state_in = S_NEXT;
         S_NEXT: state_in = flags.last_i ? S_FSTART : S_MUL;
         S_FSTART: state_in = S_FDIV;
         S_FDIV: begin
            if (flags.div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: cmd.capture = start;
         S_LOAD: begin
            cmd.load_wr  = 1'b1;
            cmd.set_load = 1'b1;
         end
         S_SRCH: begin
            cmd.srch_rd = !flags.cnt_zero;
            cmd.chk_rd  = flags.cnt_zero && flags.first_ok;
            cmd.set_nf  = flags.cnt_zero && !flags.first_ok;
         end
         S_SCMP: cmd.srch_step = 1'b1;
         S_CHK: begin
            cmd.set_nf  = !flags.hit;
            cmd.set_ang = flags.hit && !flags.angle_ok;
            cmd.b_rd    = flags.hit && flags.angle_ok;
         end
         S_BCAP: cmd.b_cap = 1'b1;
         S_RANGE: cmd.x_start = !flags.out_range;
         S_XDIV: cmd.x_done = flags.div_done;
         S_C0: cmd.c0_cap = 1'b1;
         S_MUL: cmd.mul_x = 1'b1;
         S_XP: cmd.xp_cap = 1'b1;
         S_T: cmd.t_cap = 1'b1;
         S_TSTART: cmd.t_start = 1'b1;
         S_TDIV: cmd.p_upd = flags.div_done;
         S_CRD: cmd.c_rd = 1'b1;
         S_CMUL: cmd.c_mul = 1'b1;
         S_CACC: cmd.c_acc = 1'b1;
         S_NEXT: cmd.i_inc = !flags.last_i;
         S_FSTART: cmd.f_start = 1'b1;
         S_FDIV: cmd.f_done = flags.div_done;
         S_FIN: cmd.emit = 1'b1;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

endmodule

### sv/ldl_dp.sv
module ldl_dp import ldl_pkg::*; #(
   parameter int N_FIELDS    = 32,
   parameter int ANGLE_SLOTS = 10,
   parameter int N_TERMS     = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output flag_type           flags,
   input  logic [1:0]         req_func,
   input  logic [4:0]         req_field_slot,
   input  logic [3:0]         req_angle_slot,
   input  logic [2:0]         req_term_slot,
   input  logic signed [31:0] req_load_word,
   input  logic [9:0]         req_field_strength,
   input  logic [6:0]         req_aspect_angle,
   input  logic signed [31:0] req_velocity,
   input  logic               csr_wr,
   input  logic [5:0]         csr_data,
   output logic               rsp_strobe,
   output logic signed [47:0] rsp_density,
   output logic [2:0]         rsp_status
);

   localparam int FW     = $clog2(N_FIELDS + 1);
   localparam int FAW    = $clog2(N_FIELDS);
   localparam int RW     = $clog2(ANGLE_SLOTS * N_FIELDS);
   localparam int CAW    = $clog2(ANGLE_SLOTS * N_FIELDS * N_TERMS);
   localparam int LAST_I = (N_TERMS > 1) ? 2 * N_TERMS - 3 : 0;

   function automatic logic signed [65:0] trunc30(input logic signed [65:0] v);
      logic signed [65:0] adj;
      adj = v[65] ? v + 66'sd1073741823 : v;
      return adj >>> Q_SHIFT;
   endfunction

   logic [5:0]         fiu_ff, fiu_in;
   func_type           func_ff, func_in;
   logic [4:0]         fs_ff, fs_in;
   logic [3:0]         as_ff, as_in;
   logic [2:0]         ts_ff, ts_in;
   logic [31:0]        word_ff, word_in;
   logic [9:0]         key_ff, key_in;
   logic [3:0]         a_ff, a_in;
   logic signed [31:0] vel_ff, vel_in;
   logic [FW-1:0]      n_ff, n_in, first_ff, first_in, count_ff, count_in;
   logic [RW-1:0]      row_ff, row_in;
   logic signed [31:0] b_ff, b_in;
   logic [30:0]        x_ff, x_in;
   logic signed [32:0] p_ff, p_in, pm1_ff, pm1_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [33:0] xp_ff, xp_in;
   logic signed [40:0] t_ff, t_in;
   logic signed [S_W-1:0] s_ff, s_in;
   logic signed [47:0] dens_ff, dens_in;
   status_type         stat_ff, stat_in;
   logic               strobe_ff, strobe_in;

   logic [FW-1:0]      step;
   logic [8:0]         fiu_ext;
   logic [14:0]        angle_prod;
   logic [31:0]        vm, bm;
   logic [S_W-1:0]     sm;
   logic [40:0]        tm;
   logic signed [32:0] mul_a;
   logic signed [65:0] mul_p;
   logic signed [6:0]  odd_s;
   logic signed [5:0]  i_s;
   logic signed [40:0] t_pos, t_neg;
   logic [32:0]        qc;
   logic [48:0]        dm;
   logic               neg;
   logic [RW-1:0]      ld_row, q_row;
   logic [IDX_W-1:0]   term;

   logic               fld_we, spd_we, cof_we;
   logic [FAW-1:0]     fld_addr;
   logic [RW-1:0]      spd_addr;
   logic [CAW-1:0]     cof_addr;
   logic [9:0]         fld_rdata;
   logic [31:0]        spd_rdata, cof_rdata;

   logic               div_start, div_run, div_done;
   logic [DVD_W-1:0]   div_dvd, div_quo;
   logic [31:0]        div_den;
   logic [CNT_W-1:0]   div_nb;

   assign step       = count_ff >> 1;
   assign fiu_ext    = {3'b000, fiu_ff};
   assign angle_prod = 15'(req_aspect_angle) * 15'(ANGLE_MUL);
   assign vm         = vel_ff[31] ? 32'(-vel_ff) : 32'(vel_ff);
   assign bm         = b_ff[31] ? 32'(-b_ff) : 32'(b_ff);
   assign sm         = s_ff[S_W-1] ? S_W'(-s_ff) : S_W'(s_ff);
   assign tm         = t_ff[40] ? 41'(-t_ff) : 41'(t_ff);
   assign mul_a      = cmd.c_mul ? 33'(signed'(cof_rdata)) : signed'({2'b00, x_ff});
   assign mul_p      = mul_a * p_ff;
   assign odd_s      = signed'({1'b0, i_ff, 1'b1});
   assign i_s        = signed'({1'b0, i_ff});
   assign t_pos      = odd_s * xp_ff;
   assign t_neg      = i_s * pm1_ff;
   assign ld_row     = RW'(int'(as_ff) * N_FIELDS + int'(fs_ff));
   assign q_row      = RW'(int'(a_ff) * N_FIELDS + int'(first_ff));
   assign term       = cmd.c_rd ? IDX_W'((i_ff + 1'b1) >> 1) : '0;

   assign fld_we   = cmd.load_wr && func_ff == FUNC_FIELD && (9'(fs_ff) < 9'(N_FIELDS));
   assign spd_we   = cmd.load_wr && func_ff == FUNC_SPEED && (9'(fs_ff) < 9'(N_FIELDS))
                     && (6'(as_ff) < 6'(ANGLE_SLOTS));
   assign cof_we   = cmd.load_wr && func_ff == FUNC_COEF && (9'(fs_ff) < 9'(N_FIELDS))
                     && (6'(as_ff) < 6'(ANGLE_SLOTS)) && (5'(ts_ff) < 5'(N_TERMS));
   assign fld_addr = cmd.load_wr ? FAW'(fs_ff) :
                     cmd.srch_rd ? FAW'(first_ff + step) : FAW'(first_ff);
   assign spd_addr = cmd.load_wr ? ld_row : q_row;
   assign cof_addr = cmd.load_wr ? CAW'(int'(ld_row) * N_TERMS + int'(ts_ff))
                                 : CAW'(int'(row_ff) * N_TERMS + int'(term));

   assign div_start = cmd.x_start || cmd.t_start || cmd.f_start;

   always_comb begin
      if (cmd.t_start) begin
         div_dvd = DVD_W'(tm);
         div_den = 32'(i_ff) + 32'd1;
         div_nb  = CNT_W'(T_BITS);
      end else if (cmd.f_start) begin
         div_dvd = DVD_W'(sm) << FRAC_SHIFT;
         div_den = bm;
         div_nb  = CNT_W'(F_BITS);
      end else begin
         div_dvd = DVD_W'(vm) << FRAC_SHIFT;
         div_den = bm;
         div_nb  = CNT_W'(X_BITS);
      end
   end

   assign qc = ((|div_quo[DVD_W-1:32]) || div_quo[31:0] > 32'h8000_0000) ?
               33'h0_8000_0000 : {1'b0, div_quo[31:0]};
   assign neg = s_ff[S_W-1] ^ b_ff[31];

   always_comb begin
      fiu_in    = csr_wr ? csr_data : fiu_ff;
      func_in   = func_ff;
      fs_in     = fs_ff;
      as_in     = as_ff;
      ts_in     = ts_ff;
      word_in   = word_ff;
      key_in    = key_ff;
      a_in      = a_ff;
      vel_in    = vel_ff;
      n_in      = n_ff;
      first_in  = first_ff;
      count_in  = count_ff;
      row_in    = row_ff;
      b_in      = b_ff;
      x_in      = x_ff;
      p_in      = p_ff;
      pm1_in    = pm1_ff;
      i_in      = i_ff;
      prod_in   = prod_ff;
      xp_in     = xp_ff;
      t_in      = t_ff;
      s_in      = s_ff;
      dens_in   = dens_ff;
      stat_in   = stat_ff;
      strobe_in = cmd.emit;
      dm        = '0;
      if (cmd.capture) begin
         func_in  = func_type'(req_func);
         fs_in    = req_field_slot;
         as_in    = req_angle_slot;
         ts_in    = req_term_slot;
         word_in  = req_load_word;
         key_in   = req_field_strength;
         a_in     = 4'(angle_prod >> ANGLE_SHR);
         vel_in   = req_velocity;
         n_in     = (fiu_ext >= 9'(N_FIELDS)) ? FW'(N_FIELDS) : FW'(fiu_ff);
         first_in = '0;
         count_in = (fiu_ext >= 9'(N_FIELDS)) ? FW'(N_FIELDS) : FW'(fiu_ff);
         dens_in  = '0;
         stat_in  = ST_OK;
      end
      if (cmd.set_load) stat_in = ST_LOAD_DONE;
      if (cmd.set_nf)   stat_in = ST_NO_FIELD;
      if (cmd.set_ang)  stat_in = ST_BAD_ANGLE;
      if (cmd.srch_step) begin
         if (flags.less) begin
            first_in = first_ff + step + 1'b1;
            count_in = count_ff - step - 1'b1;
         end else begin
            count_in = step;
         end
      end
      if (cmd.b_rd)  row_in = q_row;
      if (cmd.b_cap) b_in = signed'(spd_rdata);
      if (cmd.x_done) begin
         x_in   = div_quo[30:0];
         p_in   = signed'({2'b00, div_quo[30:0]});
         pm1_in = 33'sh0_4000_0000;
         i_in   = IDX_W'(1);
      end
      if (cmd.c0_cap) s_in = S_W'(signed'(cof_rdata));
      if (cmd.mul_x || cmd.c_mul) prod_in = mul_p;
      if (cmd.xp_cap) xp_in = 34'(trunc30(prod_ff));
      if (cmd.t_cap)  t_in = t_pos - t_neg;
      if (cmd.p_upd) begin
         pm1_in = p_ff;
         p_in   = t_ff[40] ? -signed'(qc) : signed'(qc);
      end
      if (cmd.c_acc) s_in = s_ff + S_W'(trunc30(prod_ff));
      if (cmd.i_inc) i_in = i_ff + 1'b1;
      if (cmd.f_done) begin
         dm = (|div_quo[DVD_W-1:48]) ? 49'h1_0000_0000_0000 : {1'b0, div_quo[47:0]};
         if (neg) begin
            if (dm > 49'h0_8000_0000_0000) begin
               dm      = 49'h0_8000_0000_0000;
               stat_in = ST_SATURATED;
            end
            dens_in = 48'(-dm);
         end else begin
            if (dm > 49'h0_7FFF_FFFF_FFFF) begin
               dm      = 49'h0_7FFF_FFFF_FFFF;
               stat_in = ST_SATURATED;
            end
            dens_in = signed'(dm[47:0]);
         end
      end
   end

   always_comb begin
      flags.cnt_zero  = count_ff == '0;
      flags.first_ok  = first_ff < n_ff;
      flags.less      = fld_rdata < key_ff;
      flags.hit       = fld_rdata == key_ff;
      flags.angle_ok  = 6'(a_ff) < 6'(ANGLE_SLOTS);
      flags.out_range = (bm == '0) || ({2'b00, vm} > {bm, 2'b00});
      flags.div_done  = div_done;
      flags.even_next = i_ff[0];
      flags.last_i    = i_ff == IDX_W'(LAST_I);
      flags.no_loop   = N_TERMS < 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff    <= 6'(FIU_RESET);
         strobe_ff <= 1'b0;
      end else begin
         fiu_ff    <= fiu_in;
         strobe_ff <= strobe_in;
      end
      func_ff  <= func_in;
      fs_ff    <= fs_in;
      as_ff    <= as_in;
      ts_ff    <= ts_in;
      word_ff  <= word_in;
      key_ff   <= key_in;
      a_ff     <= a_in;
      vel_ff   <= vel_in;
      n_ff     <= n_in;
      first_ff <= first_in;
      count_ff <= count_in;
      row_ff   <= row_in;
      b_ff     <= b_in;
      x_ff     <= x_in;
      p_ff     <= p_in;
      pm1_ff   <= pm1_in;
      i_ff     <= i_in;
      prod_ff  <= prod_in;
      xp_ff    <= xp_in;
      t_ff     <= t_in;
      s_ff     <= s_in;
      dens_ff  <= dens_in;
      stat_ff  <= stat_in;
   end

   ldl_ram #(.WIDTH(10), .DEPTH(N_FIELDS)) u_fld_ram (
      .clock   (clock),
      .we      (fld_we),
      .addr    (fld_addr),
      .wr_data (word_ff[9:0]),
      .rd_data (fld_rdata)
   );

   ldl_ram #(.WIDTH(32), .DEPTH(ANGLE_SLOTS * N_FIELDS)) u_spd_ram (
      .clock   (clock),
      .we      (spd_we),
      .addr    (spd_addr),
      .wr_data (word_ff),
      .rd_data (spd_rdata)
   );

   ldl_ram #(.WIDTH(32), .DEPTH(ANGLE_SLOTS * N_FIELDS * N_TERMS)) u_cof_ram (
      .clock   (clock),
      .we      (cof_we),
      .addr    (cof_addr),
      .wr_data (word_ff),
      .rd_data (cof_rdata)
   );

   ldl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_den),
      .nbits    (div_nb),
      .run      (div_run),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_strobe  = strobe_ff;
   assign rsp_density = dens_ff;
   assign rsp_status  = stat_ff;

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_run)
      else $error("divider restarted while running");

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("result strobe longer than one cycle");

   a_zero_density: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && (stat_ff == ST_LOAD_DONE || stat_ff == ST_NO_FIELD
                     || stat_ff == ST_BAD_ANGLE)) |-> dens_ff == '0)
      else $error("nonzero density on load or error result");

endmodule

### sv/legendre_distribution_lookup.sv
// Load items: start captures the request, then the LOAD and FIN states run before rsp_strobe;
// the next item may start while rsp_strobe is high. Queries: a binary search of the field
// table, a speed lookup, a division for x, 2*N_TERMS-3 recurrence steps (a coefficient is
// added on odd steps) and a final scaling division, all on the one bit-per-cycle divider.
// One item at a time; the receiver cannot stall, each result is shown for one cycle.
// Synchronous reset sets fields_in_use to 32 and idles the controller; tables keep contents.
module legendre_distribution_lookup import ldl_pkg::*; #(
   parameter int N_FIELDS    = 32,
   parameter int ANGLE_SLOTS = 10,
   parameter int N_TERMS     = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic [4:0]         req_field_slot,
   input  logic [3:0]         req_angle_slot,
   input  logic [2:0]         req_term_slot,
   input  logic signed [31:0] req_load_word,
   input  logic [9:0]         req_field_strength,
   input  logic [6:0]         req_aspect_angle,
   input  logic signed [31:0] req_velocity,
   output logic               rsp_strobe,
   output logic signed [47:0] rsp_density,
   output logic [2:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [5:0]         csr_data
);

   cmd_type  cmd;
   flag_type flags;

   assign csr_ready = 1'b1;

   ldl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .func  (req_func),
      .flags (flags),
      .cmd   (cmd),
      .busy  (busy)
   );

   ldl_dp #(
      .N_FIELDS    (N_FIELDS),
      .ANGLE_SLOTS (ANGLE_SLOTS),
      .N_TERMS     (N_TERMS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .flags              (flags),
      .req_func           (req_func),
      .req_field_slot     (req_field_slot),
      .req_angle_slot     (req_angle_slot),
      .req_term_slot      (req_term_slot),
      .req_load_word      (req_load_word),
      .req_field_strength (req_field_strength),
      .req_aspect_angle   (req_aspect_angle),
      .req_velocity       (req_velocity),
      .csr_wr             (csr_valid && csr_ready),
      .csr_data           (csr_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_density        (rsp_density),
      .rsp_status         (rsp_status)
   );

endmodule
